@@ src/assert_macros.svh @@
// assertion macros shared by the event queue modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define MTEQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("event queue assertion failed");

// signal holds no unknown bits outside reset
`define MTEQ_ASSERT_KNOWN(lbl, clk, rst_n, sig) \
  `MTEQ_ASSERT(lbl, clk, rst_n, !$isunknown(sig))

`endif

@@ src/mteq_pkg.sv @@
// types and codes of the multilevel timed event queue
`default_nettype none
package mteq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SERVE  = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_SERVED   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_BADPRIO  = 3'd4
  } status_e;

  typedef struct packed {
    logic        operation;
    logic [15:0] event_id;
    logic [3:0]  priority_req;
    logic [31:0] time_stamp;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] served_id;
    logic [3:0]  served_priority;
    logic [31:0] served_time;
  } out_item_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic srv;
  } lvl_ctrl_t;

endpackage
`default_nettype wire

@@ src/mteq_cell.sv @@
// one slot of a level: holds an entry and trades with its neighbors
`default_nettype none
module mteq_cell (
  input  wire                clk_i,
  input  mteq_pkg::lvl_ctrl_t ctrl_i,
  input  wire                in_range_i,
  input  wire                at_end_i,
  input  mteq_pkg::entry_t   new_entry_i,
  input  mteq_pkg::entry_t   left_entry_i,
  input  wire                left_later_i,
  input  mteq_pkg::entry_t   right_entry_i,
  output mteq_pkg::entry_t   entry_o,
  output logic               later_o
);
  import mteq_pkg::*;

  entry_t entry_q, entry_d;

  assign later_o = in_range_i && (entry_q.stamp > new_entry_i.stamp);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.srv) begin
      entry_d = right_entry_i;
    end else if (ctrl_i.ins && (later_o || at_end_i)) begin
      entry_d = left_later_i ? left_entry_i : new_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

@@ src/mteq_level.sv @@
// one priority level: a sorted row of cells and its fill count
`default_nettype none
`include "assert_macros.svh"
module mteq_level #(
  parameter int DEPTH = 16,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  mteq_pkg::lvl_ctrl_t ctrl_i,
  input  mteq_pkg::entry_t    new_entry_i,
  output logic [CNT_W-1:0]    count_o,
  output mteq_pkg::entry_t    head_o
);
  import mteq_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  entry_t           entries [DEPTH];
  logic [DEPTH-1:0] later;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_l;
    if (k == 0) begin : g_first
      assign left_e = new_entry_i;
      assign left_l = 1'b0;
    end else begin : g_mid
      assign left_e = entries[k-1];
      assign left_l = later[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_e = entries[k];
    end else begin : g_inner
      assign right_e = entries[k+1];
    end
    mteq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl_i),
      .in_range_i   (CNT_W'(k) < count_q),
      .at_end_i     (count_q == CNT_W'(k)),
      .new_entry_i  (new_entry_i),
      .left_entry_i (left_e),
      .left_later_i (left_l),
      .right_entry_i(right_e),
      .entry_o      (entries[k]),
      .later_o      (later[k])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl_i.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl_i.srv) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;
  assign head_o  = entries[0];

  `MTEQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(DEPTH))
  `MTEQ_ASSERT(a_ins_not_full, clk_i, rst_ni, ctrl_i.ins |-> count_q < CNT_W'(DEPTH))
  `MTEQ_ASSERT(a_srv_not_empty, clk_i, rst_ni, ctrl_i.srv |-> (count_q != '0 && !ctrl_i.ins))

endmodule
`default_nettype wire

@@ src/multilevel_timed_event_queue_top.sv @@
// top level of the multilevel timed event queue
`default_nettype none
`include "assert_macros.svh"
// Event queue with LEVELS priority levels of LEVEL_DEPTH sorted slots each.
// Each item is registered, then, once the output register is free, every
// cell of the addressed level compares its time stamp with the new one and
// shifts in parallel (or the served level shifts toward its head), writing
// the result into the output register. A new item is taken while that
// result still waits to be taken. No clearing pass after reset is needed.
module multilevel_timed_event_queue_top #(
  parameter int LEVELS      = 8,
  parameter int LEVEL_DEPTH = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  mteq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output mteq_pkg::out_item_t out_item_o
);
  import mteq_pkg::*;

  localparam int LVL_W = $clog2(LEVELS);
  localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);

  logic      busy_q, busy_d;
  logic      out_valid_q, out_valid_d;
  in_item_t  item_q;
  out_item_t out_item_q, out_item_d;

  logic [CNT_W-1:0] counts [LEVELS];
  entry_t           heads  [LEVELS];
  lvl_ctrl_t        ctrls  [LEVELS];

  logic             exec, bad_prio, full, found;
  logic [LVL_W-1:0] ins_lvl, sel_lvl;
  entry_t           new_entry;

  assign exec      = busy_q && (!out_valid_q || out_ready_i);
  assign bad_prio  = (item_q.priority_req == 4'd0) ||
                     ({1'b0, item_q.priority_req} > 5'(LEVELS));
  assign ins_lvl   = LVL_W'(item_q.priority_req - 4'd1);
  assign full      = counts[ins_lvl] == CNT_W'(LEVEL_DEPTH);
  assign new_entry = '{id: item_q.event_id, stamp: item_q.time_stamp};

  always_comb begin
    found   = 1'b0;
    sel_lvl = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (counts[i] != '0) begin
        found   = 1'b1;
        sel_lvl = LVL_W'(i);
      end
    end
  end

  for (genvar l = 0; l < LEVELS; l++) begin : g_level
    assign ctrls[l].ins = exec && (item_q.operation == OP_INSERT) && !bad_prio &&
                          !full && (ins_lvl == LVL_W'(l));
    assign ctrls[l].srv = exec && (item_q.operation == OP_SERVE) && found &&
                          (sel_lvl == LVL_W'(l));
    mteq_level #(
      .DEPTH(LEVEL_DEPTH),
      .CNT_W(CNT_W)
    ) u_level (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrls[l]),
      .new_entry_i(new_entry),
      .count_o    (counts[l]),
      .head_o     (heads[l])
    );
  end

  always_comb begin
    out_item_d = '{status: ST_INSERTED, served_id: '0, served_priority: '0,
                   served_time: '0};
    if (item_q.operation == OP_SERVE) begin
      if (found) begin
        out_item_d.status          = ST_SERVED;
        out_item_d.served_id       = heads[sel_lvl].id;
        out_item_d.served_priority = 4'(sel_lvl) + 4'd1;
        out_item_d.served_time     = heads[sel_lvl].stamp;
      end else begin
        out_item_d.status = ST_EMPTY;
      end
    end else if (bad_prio) begin
      out_item_d.status = ST_BADPRIO;
    end else if (full) begin
      out_item_d.status = ST_FULL;
    end
  end

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (exec) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
    end
    if (in_valid_i && in_ready_o) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
    if (exec) begin
      out_item_q <= out_item_d;
    end
  end

  assign in_ready_o  = !busy_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `MTEQ_ASSERT(a_accept_busy, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> busy_q)
  `MTEQ_ASSERT(a_exec_result, clk_i, rst_ni, exec |=> out_valid_q)
  `MTEQ_ASSERT(a_served_prio, clk_i, rst_ni,
    (out_valid_q && out_item_q.status == ST_SERVED) |-> out_item_q.served_priority != 4'd0)
  `MTEQ_ASSERT_KNOWN(a_ready_known, clk_i, rst_ni, in_ready_o)
  `MTEQ_ASSERT_KNOWN(a_valid_known, clk_i, rst_ni, out_valid_o)

endmodule
`default_nettype wire
